@@ rtl/jsfrrg_pkg.sv @@
`timescale 1ns / 1ps
package jsfrrg_pkg;

	localparam int DW         = 32;
	localparam int CNT_W      = 5;
	localparam int SEED_W     = 64;
	localparam int COUNT_W    = 64;
	localparam int BOUND_W    = 31;
	localparam int CLUMP_IN_W = 5;

	localparam logic [DW-1:0] JSF_A_INIT = 32'hf1ea5eed;
	localparam logic [DW-1:0] UMAX       = 32'hffffffff;
	localparam int            ROT_B      = 27;
	localparam int            ROT_C      = 17;

	localparam int DEF_MAX_CLUMP    = 16;
	localparam int DEF_WARMUP_STEPS = 20;

	typedef enum logic [1:0] {
		FN_RESEED = 2'd0,
		FN_RANGE  = 2'd1,
		FN_WIDE   = 2'd2,
		FN_CLUMP  = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SPLIT,
		ST_DIE,
		ST_LIMIT,
		ST_DRAW,
		ST_REDUCE,
		ST_WIDE_HI,
		ST_WIDE_LO,
		ST_LOAD,
		ST_WARM,
		ST_WARM_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic          start;
		logic [DW-1:0] dividend;
		logic [DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [DW-1:0] quot;
		logic [DW-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic load;
		logic step;
		logic both;
		logic sel;
	} gen_cmd_t;

	typedef struct packed {
		logic          done;
		logic [DW-1:0] rnd;
	} gen_rsp_t;

endpackage

@@ rtl/jsfrrg_div.sv @@
`timescale 1ns / 1ps
module jsfrrg_div (
	input  logic                clk,
	input  logic                arst_n,
	input  jsfrrg_pkg::div_req_t req,
	output jsfrrg_pkg::div_rsp_t rsp
);

	logic                       busy_q;
	logic                       done_q;
	logic [jsfrrg_pkg::CNT_W-1:0] cnt_q;
	logic [jsfrrg_pkg::DW-1:0]  rem_q;
	logic [jsfrrg_pkg::DW-1:0]  quo_q;
	logic [jsfrrg_pkg::DW-1:0]  dsr_q;
	logic [jsfrrg_pkg::DW:0]    trial;
	logic [jsfrrg_pkg::DW:0]    shifted;

	assign shifted = {rem_q, quo_q[jsfrrg_pkg::DW-1]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {jsfrrg_pkg::CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[jsfrrg_pkg::DW]) begin
				rem_q <= trial[jsfrrg_pkg::DW-1:0];
				quo_q <= {quo_q[jsfrrg_pkg::DW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[jsfrrg_pkg::DW-1:0];
				quo_q <= {quo_q[jsfrrg_pkg::DW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

@@ rtl/jsfrrg_gen.sv @@
`timescale 1ns / 1ps
module jsfrrg_gen (
	input  logic                          clk,
	input  logic                          arst_n,
	input  jsfrrg_pkg::gen_cmd_t          cmd,
	input  logic [jsfrrg_pkg::SEED_W-1:0] seed,
	output jsfrrg_pkg::gen_rsp_t          rsp
);

	logic [jsfrrg_pkg::DW-1:0] word_a_q [2];
	logic [jsfrrg_pkg::DW-1:0] word_b_q [2];
	logic [jsfrrg_pkg::DW-1:0] word_c_q [2];
	logic [jsfrrg_pkg::DW-1:0] word_d_q [2];
	logic [jsfrrg_pkg::DW-1:0] e_q      [2];
	logic [1:0]                mask_q;
	logic                      sel_q;
	logic                      phase_q;
	logic                      done_q;
	logic [jsfrrg_pkg::DW-1:0] seed_lo;
	logic [jsfrrg_pkg::DW-1:0] seed_hi;

	assign seed_lo = seed[jsfrrg_pkg::DW-1:0];
	assign seed_hi = seed[jsfrrg_pkg::SEED_W-1:jsfrrg_pkg::DW];

	function automatic logic [jsfrrg_pkg::DW-1:0] rotl(input logic [jsfrrg_pkg::DW-1:0] v,
			input int k);
		rotl = (v << k) | (v >> (jsfrrg_pkg::DW - k));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= phase_q;
			if (cmd.step) begin
				phase_q <= 1'b1;
			end else begin
				phase_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			mask_q <= cmd.both ? 2'b11 : (cmd.sel ? 2'b10 : 2'b01);
			sel_q  <= cmd.sel;
		end
		for (int s = 0; s < 2; s++) begin
			if (cmd.step) begin
				e_q[s] <= word_a_q[s] - rotl(word_b_q[s], jsfrrg_pkg::ROT_B);
			end
			if (cmd.load) begin
				word_a_q[s] <= jsfrrg_pkg::JSF_A_INIT;
				word_b_q[s] <= seed_lo;
				word_c_q[s] <= seed_lo ^ seed_hi;
				word_d_q[s] <= seed_lo;
			end else if (phase_q && mask_q[s]) begin
				word_a_q[s] <= word_b_q[s] ^ rotl(word_c_q[s], jsfrrg_pkg::ROT_C);
				word_b_q[s] <= word_c_q[s] + word_d_q[s];
				word_c_q[s] <= word_d_q[s] + e_q[s];
				word_d_q[s] <= e_q[s] + (word_b_q[s] ^ rotl(word_c_q[s], jsfrrg_pkg::ROT_C));
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rnd  = word_d_q[sel_q];

endmodule

@@ rtl/jsf_random_range_generator_core.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Signals                                          | Beat
// cfg     | in        | cfg_valid cfg_ready cfg_data                     | seed write
// in      | in        | in_valid in_ready func stream lower_bound        | one request
//         |           | upper_bound clump_factor                         |
// out     | out       | out_valid out_ready draw_value wide_value        | one result
//         |           | draw_count                                       |
// One request at a time. A generator step registers e, then updates the
// state words and raises done; the shared divider resolves one quotient
// bit a cycle. A range die runs a limit division, then draws and reduces
// until a draw is kept; a clumped draw adds one split division and repeats
// per die. A wide draw joins two generator words; a reseed loads and warms
// both streams. After reset both streams are seeded from zero, in_ready low.
// A stalled result waits in the output register while the next request is taken.
module jsf_random_range_generator_core #(
	parameter int MAX_CLUMP    = jsfrrg_pkg::DEF_MAX_CLUMP,
	parameter int WARMUP_STEPS = jsfrrg_pkg::DEF_WARMUP_STEPS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [jsfrrg_pkg::SEED_W-1:0]         cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            func,
	input  logic                                  stream,
	input  logic signed [jsfrrg_pkg::BOUND_W-1:0] lower_bound,
	input  logic signed [jsfrrg_pkg::BOUND_W-1:0] upper_bound,
	input  logic [jsfrrg_pkg::CLUMP_IN_W-1:0]     clump_factor,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [jsfrrg_pkg::BOUND_W-1:0] draw_value,
	output logic [jsfrrg_pkg::SEED_W-1:0]         wide_value,
	output logic [jsfrrg_pkg::COUNT_W-1:0]        draw_count
);

	localparam int CLUMP_W = $clog2(MAX_CLUMP + 1);
	localparam int WARM_W  = $clog2(WARMUP_STEPS + 2);
	localparam int DW      = jsfrrg_pkg::DW;

	jsfrrg_pkg::state_t   state_q, state_d;
	jsfrrg_pkg::div_req_t div_req;
	jsfrrg_pkg::div_rsp_t div_rsp;
	jsfrrg_pkg::gen_cmd_t gen_cmd;
	jsfrrg_pkg::gen_rsp_t gen_rsp;
	jsfrrg_pkg::func_t    func_q;

	logic                               boot_q;
	logic [jsfrrg_pkg::SEED_W-1:0]      seed_q;
	logic [jsfrrg_pkg::COUNT_W-1:0]     count_q;
	logic                               stream_q;
	logic [DW-1:0]                      lo_q;
	logic [DW-1:0]                      diff_q;
	logic [CLUMP_W-1:0]                 clump_q;
	logic [DW-1:0]                      sides_q;
	logic [CLUMP_W-1:0]                 extra_q;
	logic [CLUMP_W-1:0]                 die_q;
	logic [DW-1:0]                      n_q;
	logic [DW-1:0]                      lim_q;
	logic [DW-1:0]                      total_q;
	logic [DW-1:0]                      wide_hi_q;
	logic [DW-1:0]                      wide_lo_q;
	logic [WARM_W-1:0]                  warm_q;
	logic                               out_valid_q;
	logic [jsfrrg_pkg::BOUND_W-1:0]     dv_q;
	logic [jsfrrg_pkg::SEED_W-1:0]      wv_q;
	logic [jsfrrg_pkg::COUNT_W-1:0]     dc_q;

	logic                               in_fire;
	logic                               count_inc;
	logic                               empty;
	logic                               die_last;
	logic                               die_extra;
	logic                               m_zero;
	logic [DW-1:0]                      n_next;
	logic                               hit;
	logic                               warm_end;
	logic                               out_free;
	logic [DW-1:0]                      lo_ext;
	logic [DW-1:0]                      hi_ext;
	logic [CLUMP_W-1:0]                 clump_sat;
	logic [DW-1:0]                      draw_sum;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == jsfrrg_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign lo_ext    = {{(DW - jsfrrg_pkg::BOUND_W){lower_bound[jsfrrg_pkg::BOUND_W-1]}},
		lower_bound};
	assign hi_ext    = {{(DW - jsfrrg_pkg::BOUND_W){upper_bound[jsfrrg_pkg::BOUND_W-1]}},
		upper_bound};
	assign clump_sat = (32'(clump_factor) > 32'(MAX_CLUMP)) ? CLUMP_W'(MAX_CLUMP)
		: CLUMP_W'(clump_factor);

	assign empty     = diff_q[DW-1] || (diff_q == '0);
	assign die_last  = (die_q == clump_q);
	assign die_extra = (die_q < extra_q);
	assign m_zero    = (sides_q == '0) && !die_extra;
	assign n_next    = sides_q + (die_extra ? DW'(2) : DW'(1));
	assign hit       = (div_rsp.quot < n_q);
	assign warm_end  = (warm_q == WARM_W'(WARMUP_STEPS));
	assign draw_sum  = total_q + lo_q;

	jsfrrg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	jsfrrg_gen u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (gen_cmd),
		.seed   (seed_q),
		.rsp    (gen_rsp)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			jsfrrg_pkg::ST_IDLE: begin
				if (in_fire) state_d = jsfrrg_pkg::ST_SETUP;
			end
			jsfrrg_pkg::ST_SETUP: begin
				unique case (func_q)
					jsfrrg_pkg::FN_RESEED: state_d = jsfrrg_pkg::ST_LOAD;
					jsfrrg_pkg::FN_WIDE:   state_d = jsfrrg_pkg::ST_WIDE_HI;
					default: begin
						if (empty) state_d = jsfrrg_pkg::ST_DONE;
						else if (clump_q > CLUMP_W'(1)) state_d = jsfrrg_pkg::ST_SPLIT;
						else state_d = jsfrrg_pkg::ST_DIE;
					end
				endcase
			end
			jsfrrg_pkg::ST_SPLIT: begin
				if (div_rsp.done) state_d = jsfrrg_pkg::ST_DIE;
			end
			jsfrrg_pkg::ST_DIE: begin
				if (die_last) state_d = jsfrrg_pkg::ST_DONE;
				else if (!m_zero) state_d = jsfrrg_pkg::ST_LIMIT;
			end
			jsfrrg_pkg::ST_LIMIT: begin
				if (div_rsp.done) state_d = jsfrrg_pkg::ST_DRAW;
			end
			jsfrrg_pkg::ST_DRAW: begin
				if (gen_rsp.done) state_d = jsfrrg_pkg::ST_REDUCE;
			end
			jsfrrg_pkg::ST_REDUCE: begin
				if (div_rsp.done) state_d = hit ? jsfrrg_pkg::ST_DIE : jsfrrg_pkg::ST_DRAW;
			end
			jsfrrg_pkg::ST_WIDE_HI: begin
				if (gen_rsp.done) state_d = jsfrrg_pkg::ST_WIDE_LO;
			end
			jsfrrg_pkg::ST_WIDE_LO: begin
				if (gen_rsp.done) state_d = jsfrrg_pkg::ST_DONE;
			end
			jsfrrg_pkg::ST_LOAD: state_d = jsfrrg_pkg::ST_WARM;
			jsfrrg_pkg::ST_WARM: begin
				if (!warm_end) state_d = jsfrrg_pkg::ST_WARM_WAIT;
				else if (boot_q) state_d = jsfrrg_pkg::ST_IDLE;
				else state_d = jsfrrg_pkg::ST_DONE;
			end
			jsfrrg_pkg::ST_WARM_WAIT: begin
				if (gen_rsp.done) state_d = jsfrrg_pkg::ST_WARM;
			end
			jsfrrg_pkg::ST_DONE: begin
				if (out_free) state_d = jsfrrg_pkg::ST_IDLE;
			end
			default: state_d = jsfrrg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		div_req   = '0;
		gen_cmd   = '0;
		count_inc = 1'b0;
		gen_cmd.sel = stream_q;
		unique case (state_q)
			jsfrrg_pkg::ST_SETUP: begin
				case (func_q)
					jsfrrg_pkg::FN_WIDE: begin
						gen_cmd.step = 1'b1;
						count_inc    = !stream_q;
					end
					jsfrrg_pkg::FN_RANGE, jsfrrg_pkg::FN_CLUMP: begin
						if (!empty && clump_q > CLUMP_W'(1)) begin
							div_req.start    = 1'b1;
							div_req.dividend = diff_q;
							div_req.divisor  = DW'(clump_q);
						end
					end
					default: ;
				endcase
			end
			jsfrrg_pkg::ST_DIE: begin
				if (!die_last && !m_zero) begin
					div_req.start    = 1'b1;
					div_req.dividend = jsfrrg_pkg::UMAX;
					div_req.divisor  = n_next;
					count_inc        = !stream_q;
				end
			end
			jsfrrg_pkg::ST_LIMIT: begin
				gen_cmd.step = div_rsp.done;
			end
			jsfrrg_pkg::ST_DRAW: begin
				if (gen_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = gen_rsp.rnd;
					div_req.divisor  = lim_q;
				end
			end
			jsfrrg_pkg::ST_REDUCE: begin
				gen_cmd.step = div_rsp.done && !hit;
			end
			jsfrrg_pkg::ST_WIDE_HI: begin
				gen_cmd.step = gen_rsp.done;
			end
			jsfrrg_pkg::ST_LOAD: begin
				gen_cmd.load = 1'b1;
			end
			jsfrrg_pkg::ST_WARM: begin
				gen_cmd.step = !warm_end;
				gen_cmd.both = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jsfrrg_pkg::ST_LOAD;
			boot_q      <= 1'b1;
			seed_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) seed_q <= cfg_data;
			if (count_inc) count_q <= count_q + 1'b1;
			if (state_q == jsfrrg_pkg::ST_WARM && warm_end) boot_q <= 1'b0;
			if (state_q == jsfrrg_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q   <= jsfrrg_pkg::func_t'(func);
			stream_q <= stream;
			lo_q     <= lo_ext;
			diff_q   <= hi_ext - lo_ext;
			clump_q  <= (jsfrrg_pkg::func_t'(func) == jsfrrg_pkg::FN_CLUMP
				&& clump_sat > CLUMP_W'(1)) ? clump_sat : CLUMP_W'(1);
			sides_q  <= hi_ext - lo_ext;
			extra_q  <= '0;
			die_q    <= '0;
			total_q  <= '0;
		end
		if (state_q == jsfrrg_pkg::ST_SPLIT && div_rsp.done) begin
			sides_q <= div_rsp.quot;
			extra_q <= div_rsp.rem[CLUMP_W-1:0];
		end
		if (state_q == jsfrrg_pkg::ST_DIE && !die_last) begin
			if (m_zero) die_q <= die_q + 1'b1;
			else n_q <= n_next;
		end
		if (state_q == jsfrrg_pkg::ST_LIMIT && div_rsp.done) lim_q <= div_rsp.quot;
		if (state_q == jsfrrg_pkg::ST_REDUCE && div_rsp.done && hit) begin
			total_q <= total_q + div_rsp.quot;
			die_q   <= die_q + 1'b1;
		end
		if (state_q == jsfrrg_pkg::ST_WIDE_HI && gen_rsp.done) wide_hi_q <= gen_rsp.rnd;
		if (state_q == jsfrrg_pkg::ST_WIDE_LO && gen_rsp.done) wide_lo_q <= gen_rsp.rnd;
		if (state_q == jsfrrg_pkg::ST_LOAD) warm_q <= '0;
		if (state_q == jsfrrg_pkg::ST_WARM_WAIT && gen_rsp.done) warm_q <= warm_q + 1'b1;
		if (state_q == jsfrrg_pkg::ST_DONE && out_free) begin
			dc_q <= count_q;
			case (func_q)
				jsfrrg_pkg::FN_RANGE, jsfrrg_pkg::FN_CLUMP: begin
					dv_q <= draw_sum[jsfrrg_pkg::BOUND_W-1:0];
					wv_q <= '0;
				end
				jsfrrg_pkg::FN_WIDE: begin
					dv_q <= '0;
					wv_q <= {wide_hi_q, wide_lo_q};
				end
				default: begin
					dv_q <= '0;
					wv_q <= '0;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign draw_value = dv_q;
	assign wide_value = wv_q;
	assign draw_count = dc_q;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

	localparam logic [31:0] JSF_SEED_A = 32'hf1ea5eed;
	localparam int JSF_ROT_B = 27;
	localparam int JSF_ROT_C = 17;
	localparam int MAX_DICE = 16;
	localparam int WARM_STEPS = 20;
	localparam logic signed [30:0] B_MIN = {1'b1, 30'd0};
	localparam logic signed [30:0] B_MAX = {1'b0, {30{1'b1}}};

	typedef struct {
		jsfrrg_pkg::func_t fn;
		logic strm;
		logic signed [30:0] lo;
		logic signed [30:0] hi;
		logic [4:0] clump;
	} draw_req_t;

	typedef struct {
		logic signed [30:0] draw;
		logic [63:0] wide;
		logic [63:0] count;
	} draw_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = '0;
	logic stream = 1'b0;
	logic signed [30:0] lower_bound = '0;
	logic signed [30:0] upper_bound = '0;
	logic [4:0] clump_factor = '0;
	logic out_valid;
	logic out_ready = 1'b1;
	logic signed [30:0] draw_value;
	logic [63:0] wide_value;
	logic [63:0] draw_count;

	jsf_random_range_generator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.stream(stream),
		.lower_bound(lower_bound),
		.upper_bound(upper_bound),
		.clump_factor(clump_factor),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.draw_value(draw_value),
		.wide_value(wide_value),
		.draw_count(draw_count)
	);

	logic [31:0] jsf_a [2];
	logic [31:0] jsf_b [2];
	logic [31:0] jsf_c [2];
	logic [31:0] jsf_d [2];
	logic [63:0] model_count;
	logic [63:0] model_seed;

	draw_res_t pending_results[$];
	int mismatch_count = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	function automatic logic [31:0] rotl32(logic [31:0] v, int k);
		return (v << k) | (v >> (32 - k));
	endfunction

	function automatic logic [31:0] jsf_next(bit s);
		logic [31:0] e;
		e = jsf_a[s] - rotl32(jsf_b[s], JSF_ROT_B);
		jsf_a[s] = jsf_b[s] ^ rotl32(jsf_c[s], JSF_ROT_C);
		jsf_b[s] = jsf_c[s] + jsf_d[s];
		jsf_c[s] = jsf_d[s] + e;
		jsf_d[s] = e + jsf_a[s];
		return jsf_d[s];
	endfunction

	function automatic void jsf_load(bit s, logic [63:0] sd);
		logic [31:0] dummy;
		jsf_a[s] = JSF_SEED_A;
		jsf_b[s] = sd[31:0];
		jsf_c[s] = sd[31:0] ^ sd[63:32];
		jsf_d[s] = sd[31:0];
		for (int i = 0; i < WARM_STEPS; i++)
			dummy = jsf_next(s);
	endfunction

	function automatic logic [63:0] pick_below(logic [63:0] n, bit s);
		logic [63:0] div;
		logic [63:0] r;
		div = 64'h0000_0000_ffff_ffff / n;
		do
			r = {32'd0, jsf_next(s)} / div;
		while (r >= n);
		return r;
	endfunction

	function automatic longint uniform_draw(longint lo, longint hi, bit s);
		if (hi <= lo)
			return lo;
		if (!s)
			model_count++;
		return lo + longint'(pick_below(64'(hi - lo + 1), s));
	endfunction

	function automatic draw_res_t predict_draw(draw_req_t r);
		draw_res_t res;
		longint lo, hi, dv, total, sides;
		longint unsigned span, extra;
		int dice;
		logic [31:0] h, l;
		lo = longint'(r.lo);
		hi = longint'(r.hi);
		dv = 0;
		res.wide = '0;
		case (r.fn)
			jsfrrg_pkg::FN_RESEED: begin
				jsf_load(0, model_seed);
				jsf_load(1, model_seed);
			end
			jsfrrg_pkg::FN_RANGE: begin
				dv = uniform_draw(lo, hi, r.strm);
			end
			jsfrrg_pkg::FN_WIDE: begin
				if (!r.strm)
					model_count++;
				h = jsf_next(r.strm);
				l = jsf_next(r.strm);
				res.wide = {h, l};
			end
			default: begin
				dice = (r.clump > MAX_DICE) ? MAX_DICE : int'(r.clump);
				if (hi <= lo) begin
					dv = lo;
				end else if (dice <= 1) begin
					dv = uniform_draw(lo, hi, r.strm);
				end else begin
					span = hi - lo;
					sides = span / dice;
					extra = span % dice;
					total = 0;
					for (int i = 0; i < dice; i++)
						total += uniform_draw(0, sides + ((i < extra) ? 1 : 0), r.strm);
					dv = total + lo;
				end
			end
		endcase
		res.draw = dv[30:0];
		res.count = model_count;
		return res;
	endfunction

	function automatic draw_req_t make_req(jsfrrg_pkg::func_t fn, bit s,
			logic signed [30:0] lo, logic signed [30:0] hi, logic [4:0] clump);
		draw_req_t r;
		r.fn = fn;
		r.strm = s;
		r.lo = lo;
		r.hi = hi;
		r.clump = clump;
		return r;
	endfunction

	function automatic draw_req_t random_req();
		draw_req_t r;
		logic signed [30:0] tmp;
		int pick;
		pick = $urandom_range(0, 99);
		r.fn = (pick < 4) ? jsfrrg_pkg::FN_RESEED : (pick < 38) ? jsfrrg_pkg::FN_RANGE :
			(pick < 60) ? jsfrrg_pkg::FN_WIDE : jsfrrg_pkg::FN_CLUMP;
		r.strm = 1'($urandom_range(0, 1));
		r.lo = 31'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			r.hi = r.lo + 31'($urandom_range(1, 64));
		end else if (pick < 70) begin
			r.hi = 31'($urandom());
			if (r.hi < r.lo && $urandom_range(0, 4) != 0) begin
				tmp = r.lo;
				r.lo = r.hi;
				r.hi = tmp;
			end
		end else if (pick < 80) begin
			r.hi = r.lo - 31'($urandom_range(0, 3));
		end else begin
			r.lo = $urandom_range(0, 1) ? B_MIN : B_MIN + 31'($urandom_range(0, 255));
			r.hi = B_MAX - 31'($urandom_range(0, 255));
		end
		pick = $urandom_range(0, 99);
		r.clump = (pick < 70) ? 5'($urandom_range(0, 4)) :
			(pick < 92) ? 5'($urandom_range(5, 8)) : 5'($urandom_range(9, 31));
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic send_item(draw_req_t r);
		int gap;
		if ($urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= r.fn;
		stream <= r.strm;
		lower_bound <= r.lo;
		upper_bound <= r.hi;
		clump_factor <= r.clump;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(predict_draw(r));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_seed(logic [63:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_seed = v;
	endtask

	task automatic test_reset_stream();
		gap_pct = 20;
		stall_pct = 20;
		send_item(make_req(jsfrrg_pkg::FN_RANGE, 0, B_MIN, B_MAX, 5'd0));
		send_item(make_req(jsfrrg_pkg::FN_RANGE, 1, B_MIN, B_MAX, 5'd0));
		send_item(make_req(jsfrrg_pkg::FN_WIDE, 0, B_MAX, B_MIN, 5'd31));
		send_item(make_req(jsfrrg_pkg::FN_WIDE, 1, B_MIN, B_MAX, 5'd0));
		send_item(make_req(jsfrrg_pkg::FN_RANGE, 0, 31'sd5, 31'sd5, 5'd0));
		send_item(make_req(jsfrrg_pkg::FN_RANGE, 1, B_MAX, B_MIN, 5'd0));
		send_item(make_req(jsfrrg_pkg::FN_RANGE, 0, 31'sd0, 31'sd1, 5'd0));
		send_item(make_req(jsfrrg_pkg::FN_CLUMP, 0, -31'sd10, 31'sd10, 5'd0));
		send_item(make_req(jsfrrg_pkg::FN_CLUMP, 0, B_MIN, B_MAX, 5'd1));
		send_item(make_req(jsfrrg_pkg::FN_CLUMP, 1, B_MIN, B_MAX, 5'd16));
		send_item(make_req(jsfrrg_pkg::FN_CLUMP, 0, -31'sd100, 31'sd100, 5'd31));
		send_item(make_req(jsfrrg_pkg::FN_CLUMP, 0, 31'sd7, 31'sd10, 5'd5));
		send_item(make_req(jsfrrg_pkg::FN_CLUMP, 1, 31'sd20, -31'sd20, 5'd3));
		send_item(make_req(jsfrrg_pkg::FN_RESEED, 0, 31'sd0, 31'sd0, 5'd0));
		send_item(make_req(jsfrrg_pkg::FN_RANGE, 0, -31'sd3, 31'sd3, 5'd0));
		drain();
	endtask

	task automatic test_seed_extremes();
		write_seed('1);
		send_item(make_req(jsfrrg_pkg::FN_RESEED, 1, B_MAX, B_MAX, 5'd31));
		send_item(make_req(jsfrrg_pkg::FN_WIDE, 0, 31'sd0, 31'sd0, 5'd0));
		send_item(make_req(jsfrrg_pkg::FN_RANGE, 1, -31'sd1000, 31'sd1000, 5'd0));
		drain();
		write_seed('0);
		send_item(make_req(jsfrrg_pkg::FN_RESEED, 0, 31'sd0, 31'sd0, 5'd0));
		send_item(make_req(jsfrrg_pkg::FN_WIDE, 1, 31'sd0, 31'sd0, 5'd0));
		drain();
		write_seed(64'h8000_0000_0000_0001);
		send_item(make_req(jsfrrg_pkg::FN_RESEED, 0, 31'sd0, 31'sd0, 5'd0));
		send_item(make_req(jsfrrg_pkg::FN_CLUMP, 0, 31'sd0, 31'sd40, 5'd16));
		drain();
	endtask

	task automatic test_random_mix();
		logic [63:0] sd;
		int pick;
		for (int p = 0; p < 8; p++) begin
			pick = $urandom_range(0, 7);
			sd = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom(), $urandom()};
			pick = $urandom_range(0, 2);
			gap_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 45;
			pick = $urandom_range(0, 2);
			stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 45;
			write_seed(sd);
			send_item(make_req(jsfrrg_pkg::FN_RESEED, 1'($urandom_range(0, 1)),
				31'sd0, 31'sd0, 5'd0));
			repeat (120) send_item(random_req());
			drain();
		end
	endtask

	task automatic test_steady_flow();
		gap_pct = 0;
		stall_pct = 0;
		write_seed({$urandom(), $urandom()});
		send_item(make_req(jsfrrg_pkg::FN_RESEED, 0, 31'sd0, 31'sd0, 5'd0));
		repeat (100) send_item(random_req());
		drain();
	endtask

	initial begin : clock_gen
		forever #5 clk = ~clk;
	end

	initial begin : sink_pace
		int hold;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				hold = $urandom_range(1, 13);
				repeat (hold) @(posedge clk);
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 63) == 0) begin
				hold = $urandom_range(20, 120);
				repeat (hold) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		draw_res_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing pending");
			end else begin
				want = pending_results.pop_front();
				if (draw_value !== want.draw)
					report_mismatch($sformatf("draw_value %0d, want %0d", draw_value, want.draw));
				if (wide_value !== want.wide)
					report_mismatch($sformatf("wide_value %h, want %h", wide_value, want.wide));
				if (draw_count !== want.count)
					report_mismatch($sformatf("draw_count %0d, want %0d", draw_count, want.count));
			end
		end
	end

	initial begin : watchdog
		#200ms;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : run_tests
		model_seed = '0;
		model_count = '0;
		jsf_load(0, '0);
		jsf_load(1, '0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_stream();
		test_seed_extremes();
		test_random_mix();
		test_steady_flow();
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
